// ===== sv/assert_macros.svh =====
// Assertion macros shared by the decoder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is high
`define PSC_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("decoder assertion failed");

// A condition that must never be seen
`define PSC_NEVER(lbl, expr) \
   `PSC_ASSERT(lbl, !(expr))

`endif

// ===== sv/psc_pkg.sv =====
// Types and constants for the power-supply serial command decoder
`timescale 1ns / 1ps

package psc_pkg;

   // Carriage return ends a command
   localparam logic [7:0] CR_BYTE = 8'h0D;

   // Result action codes
   typedef enum logic [2:0] {
      ACT_NONE        = 3'd0,
      ACT_POWER_ON    = 3'd1,
      ACT_POWER_OFF   = 3'd2,
      ACT_METER_READ  = 3'd3,
      ACT_DIAL_SET    = 3'd4,
      ACT_BAD_COMMAND = 3'd5,
      ACT_REPORT_ONLY = 3'd6
   } action_type;

   // One result transaction
   typedef struct packed {
      action_type  action;
      logic [1:0]  channel_out;
      logic [3:0]  meter_index;
      logic [2:0]  dial_index;
      logic [13:0] dial_value;
   } rsp_type;

endpackage

// ===== sv/psc_in_reg.sv =====
// Input register stage holding one received byte
`timescale 1ns / 1ps

module psc_in_reg (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       advance,
   output logic       held_valid,
   output logic [7:0] held_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;

   // free when empty or when the held byte moves on this cycle
   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

endmodule

// ===== sv/psc_parse.sv =====
// Command grammar parser: parser state plus next-state and result decode
`timescale 1ns / 1ps

module psc_parse (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic [7:0]       rx_byte,
   output psc_pkg::rsp_type result
);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'd0,
      ST_CMD   = 4'd1,
      ST_VAL1  = 4'd2,
      ST_DIG1  = 4'd3,
      ST_DIG2  = 4'd4,
      ST_DIG3  = 4'd5,
      ST_DIG4  = 4'd6,
      ST_TERMN = 4'd7,
      ST_TERM1 = 4'd8
   } state_type;

   // held command codes
   localparam logic [2:0] CMD_Z = 3'd0;
   localparam logic [2:0] CMD_P = 3'd1;
   localparam logic [2:0] CMD_N = 3'd2;
   localparam logic [2:0] CMD_M = 3'd3;
   localparam logic [2:0] CMD_S = 3'd4;

   // held value character codes
   localparam logic [1:0] VC_ON  = 2'd0;
   localparam logic [1:0] VC_OFF = 2'd1;
   localparam logic [1:0] VC_V   = 2'd2;
   localparam logic [1:0] VC_I   = 2'd3;

   // ASCII characters of the grammar
   localparam logic [7:0] CH_A    = 8'h41;
   localparam logic [7:0] CH_D    = 8'h44;
   localparam logic [7:0] CH_Z    = 8'h5A;
   localparam logic [7:0] CH_P    = 8'h50;
   localparam logic [7:0] CH_N    = 8'h4E;
   localparam logic [7:0] CH_M    = 8'h4D;
   localparam logic [7:0] CH_S    = 8'h53;
   localparam logic [7:0] CH_V    = 8'h56;
   localparam logic [7:0] CH_I    = 8'h49;
   localparam logic [7:0] CH_ONE  = 8'h31;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] LOWER_A = 8'h61;
   localparam logic [7:0] LOWER_Z = 8'h7A;
   localparam logic [7:0] CASE_GAP = 8'h20;

   state_type   state_ff, state_in;
   logic [1:0]  chan_ff, chan_in;
   logic [2:0]  cmd_ff, cmd_in;
   logic [1:0]  vchar_ff, vchar_in;
   logic [13:0] acc_ff, acc_in;

   logic [7:0]  upper;
   logic        is_digit;
   logic [3:0]  digit;
   logic [13:0] acc_x10;

   always_comb begin
      // fold lower case to upper case
      upper    = ((rx_byte >= LOWER_A) && (rx_byte <= LOWER_Z)) ? rx_byte - CASE_GAP : rx_byte;
      is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
      digit    = rx_byte[3:0];
      // acc*10 + digit, wrapped to 14 bits
      acc_x10  = {acc_ff[10:0], 3'b000} + {acc_ff[12:0], 1'b0} + {10'd0, digit};

      state_in = state_ff;
      chan_in  = chan_ff;
      cmd_in   = cmd_ff;
      vchar_in = vchar_ff;
      acc_in   = acc_ff;
      result   = '0;
      result.action = psc_pkg::ACT_NONE;

      unique case (state_ff)
         ST_CMD: begin
            state_in = ST_VAL1;
            priority if (upper == CH_Z) begin
               cmd_in = CMD_Z;
            end else if (upper == CH_P) begin
               cmd_in = CMD_P;
            end else if (upper == CH_N) begin
               cmd_in = CMD_N;
            end else if (upper == CH_M) begin
               cmd_in   = CMD_M;
               state_in = ST_DIG1;
            end else if (upper == CH_S) begin
               cmd_in   = CMD_S;
               state_in = ST_DIG1;
            end else begin
               result.action = psc_pkg::ACT_BAD_COMMAND;
               state_in      = ST_IDLE;
            end
         end
         ST_VAL1: begin
            state_in = ST_TERM1;
            priority if (rx_byte == CH_ONE) begin
               vchar_in = VC_ON;
            end else if (rx_byte == CH_ZERO) begin
               vchar_in = VC_OFF;
            end else if (upper == CH_V) begin
               vchar_in = VC_V;
            end else if (upper == CH_I) begin
               vchar_in = VC_I;
            end else begin
               result.action = psc_pkg::ACT_BAD_COMMAND;
               state_in      = ST_IDLE;
            end
         end
         ST_DIG1: begin
            if (is_digit) begin
               acc_in   = {10'd0, digit};
               state_in = ST_DIG2;
            end else begin
               result.action = psc_pkg::ACT_BAD_COMMAND;
               state_in      = ST_IDLE;
            end
         end
         ST_DIG2, ST_DIG3, ST_DIG4, ST_TERMN: begin
            priority if ((state_ff != ST_TERMN) && is_digit) begin
               acc_in = acc_x10;
               unique case (state_ff)
                  ST_DIG2: state_in = ST_DIG3;
                  ST_DIG3: state_in = ST_DIG4;
                  default: state_in = ST_TERMN;
               endcase
            end else if (rx_byte == psc_pkg::CR_BYTE) begin
               result.action      = psc_pkg::ACT_DIAL_SET;
               result.channel_out = chan_ff;
               result.dial_index  = {chan_ff, cmd_ff == CMD_S};
               result.dial_value  = acc_ff;
               state_in           = ST_IDLE;
            end else begin
               result.action = psc_pkg::ACT_BAD_COMMAND;
               state_in      = ST_IDLE;
            end
         end
         ST_TERM1: begin
            state_in = ST_IDLE;
            priority if (rx_byte != psc_pkg::CR_BYTE) begin
               result.action = psc_pkg::ACT_BAD_COMMAND;
            end else if (vchar_ff == VC_ON) begin
               result.action      = psc_pkg::ACT_POWER_ON;
               result.channel_out = chan_ff;
            end else if (vchar_ff == VC_OFF) begin
               result.action      = psc_pkg::ACT_POWER_OFF;
               result.channel_out = chan_ff;
            end else if ((cmd_ff == CMD_P) || (cmd_ff == CMD_N)) begin
               result.action      = psc_pkg::ACT_METER_READ;
               result.channel_out = chan_ff;
               result.meter_index = {chan_ff, cmd_ff == CMD_N, vchar_ff == VC_I};
            end else begin
               // Z with a meter character: nothing to read
               result.action      = psc_pkg::ACT_REPORT_ONLY;
               result.channel_out = chan_ff;
            end
         end
         default: begin
            // idle, and any undefined state behaves as idle
            state_in = ST_IDLE;
            if ((upper >= CH_A) && (upper <= CH_D)) begin
               chan_in  = upper[1:0] - CH_A[1:0];
               state_in = ST_CMD;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         chan_ff  <= '0;
         cmd_ff   <= CMD_Z;
         vchar_ff <= VC_ON;
         acc_ff   <= '0;
      end else if (step) begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
         cmd_ff   <= cmd_in;
         vchar_ff <= vchar_in;
         acc_ff   <= acc_in;
      end
   end

endmodule

// ===== sv/psu_serial_command_decoder.sv =====
// Top level of the power-supply serial command decoder
// An accepted byte passes through the input register and then the result register to the rsp_ outputs.
// Throughput: one byte per cycle unless rsp_ready stalls; the input register feeds the parser and result
// register directly, and every byte gives exactly one result transaction.
// Reset (synchronous, active high) empties both registers and returns the parser
// to idle with channel, command, value character and digit value cleared.
`timescale 1ns / 1ps

module psu_serial_command_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_action,
   output logic [1:0]  rsp_channel_out,
   output logic [3:0]  rsp_meter_index,
   output logic [2:0]  rsp_dial_index,
   output logic [13:0] rsp_dial_value
);

   logic             held_valid;
   logic [7:0]       held_byte;
   logic             load_out, advance;
   logic             rsp_valid_ff, rsp_valid_in;
   psc_pkg::rsp_type step_result;
   psc_pkg::rsp_type rsp_ff;

   // output register can take a result when empty or being drained
   assign load_out = !rsp_valid_ff || rsp_ready;
   assign advance  = held_valid && load_out;

   psc_in_reg u_in_reg (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .advance     (advance),
      .held_valid  (held_valid),
      .held_byte   (held_byte)
   );

   psc_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (held_byte),
      .result  (step_result)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = held_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_ff <= step_result;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_action      = rsp_ff.action;
   assign rsp_channel_out = rsp_ff.channel_out;
   assign rsp_meter_index = rsp_ff.meter_index;
   assign rsp_dial_index  = rsp_ff.dial_index;
   assign rsp_dial_value  = rsp_ff.dial_value;

   // checks
`include "assert_macros.svh"

   `PSC_ASSERT(a_held_moves, (held_valid && !rsp_valid_ff) |=> rsp_valid_ff)
   `PSC_ASSERT(a_meter_chan, (rsp_valid && (rsp_action == psc_pkg::ACT_METER_READ)) |-> (rsp_meter_index[3:2] == rsp_channel_out))
   `PSC_NEVER(a_value_only_dial, rsp_valid && (rsp_action != psc_pkg::ACT_DIAL_SET) && (rsp_dial_value != 14'd0))
   `PSC_ASSERT(a_step_fills, advance |=> rsp_valid_ff)

endmodule

// ===== verif/psu_serial_command_decoder_tb.sv =====
// Testbench for the power-supply serial command decoder: directed table, then random commands
`timescale 1ns / 1ps

module psu_serial_command_decoder_tb;

   // Parser states, command and value-character codes of the decoder's own model
   typedef enum logic [3:0] {
      PS_IDLE, PS_CMD, PS_VAL1, PS_DIG1, PS_DIG2, PS_DIG3, PS_DIG4, PS_TERMN, PS_TERM1
   } parse_state_type;
   typedef enum logic [2:0] {
      CMD_RELAY, CMD_POSITIVE, CMD_NEGATIVE, CMD_MAX_DIAL, CMD_SET_DIAL
   } command_code_type;
   typedef enum logic [1:0] {VAL_ON, VAL_OFF, VAL_VOLTS, VAL_AMPS} value_code_type;
   typedef enum logic [1:0] {RDY_ALWAYS, RDY_RANDOM, RDY_QUARTER, RDY_SPARSE} ready_mode_type;

   // One row of the directed table
   typedef struct {
      logic [7:0]       rx_byte;
      logic             pinned;
      psc_pkg::rsp_type want;
   } stim_row_type;

   localparam int RANDOM_BYTES = 1150;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_action;
   logic [1:0]  rsp_channel_out;
   logic [3:0]  rsp_meter_index;
   logic [2:0]  rsp_dial_index;
   logic [13:0] rsp_dial_value;

   // Typed-in expectation travelling alongside the byte on the request side
   logic             pin_expected = 1'b0;
   psc_pkg::rsp_type pinned_rsp = '0;

   // Decoder model state
   parse_state_type  cur_state = PS_IDLE;
   logic [1:0]       held_chan = '0;
   command_code_type held_cmd = CMD_RELAY;
   value_code_type   held_val = VAL_ON;
   logic [13:0]      dig_acc = '0;

   psc_pkg::rsp_type expected_rsps[$];
   stim_row_type     directed_rows[$];
   logic [7:0]       command_bytes[$];
   int               error_count = 0;
   int               burst_left = 0;
   ready_mode_type   stall_mode = RDY_ALWAYS;
   logic [5:0]       stall_count = '0;

   psu_serial_command_decoder i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_action      (rsp_action),
      .rsp_channel_out (rsp_channel_out),
      .rsp_meter_index (rsp_meter_index),
      .rsp_dial_index  (rsp_dial_index),
      .rsp_dial_value  (rsp_dial_value)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Decode one byte: returns the result it gives and advances the parser
   function automatic psc_pkg::rsp_type decode_byte(input logic [7:0] b);
      logic [7:0]       u;
      psc_pkg::rsp_type r;
      u = (b >= "a" && b <= "z") ? b - 8'h20 : b;
      r = '0;
      r.action = psc_pkg::ACT_NONE;
      case (cur_state)
         PS_CMD: begin
            cur_state = PS_VAL1;
            if (u == "Z") held_cmd = CMD_RELAY;
            else if (u == "P") held_cmd = CMD_POSITIVE;
            else if (u == "N") held_cmd = CMD_NEGATIVE;
            else if (u == "M" || u == "S") begin
               held_cmd  = (u == "S") ? CMD_SET_DIAL : CMD_MAX_DIAL;
               cur_state = PS_DIG1;
            end else begin
               r.action  = psc_pkg::ACT_BAD_COMMAND;
               cur_state = PS_IDLE;
            end
         end
         PS_VAL1: begin
            cur_state = PS_TERM1;
            if (b == "1") held_val = VAL_ON;
            else if (b == "0") held_val = VAL_OFF;
            else if (u == "V") held_val = VAL_VOLTS;
            else if (u == "I") held_val = VAL_AMPS;
            else begin
               r.action  = psc_pkg::ACT_BAD_COMMAND;
               cur_state = PS_IDLE;
            end
         end
         PS_DIG1: begin
            if (b >= "0" && b <= "9") begin
               dig_acc   = {10'd0, b[3:0]};
               cur_state = PS_DIG2;
            end else begin
               r.action  = psc_pkg::ACT_BAD_COMMAND;
               cur_state = PS_IDLE;
            end
         end
         PS_DIG2, PS_DIG3, PS_DIG4, PS_TERMN: begin
            if (cur_state != PS_TERMN && b >= "0" && b <= "9") begin
               dig_acc = dig_acc * 14'd10 + {10'd0, b[3:0]};
               case (cur_state)
                  PS_DIG2: cur_state = PS_DIG3;
                  PS_DIG3: cur_state = PS_DIG4;
                  default: cur_state = PS_TERMN;
               endcase
            end else if (b == psc_pkg::CR_BYTE) begin
               r.action      = psc_pkg::ACT_DIAL_SET;
               r.channel_out = held_chan;
               r.dial_index  = {held_chan, held_cmd == CMD_SET_DIAL};
               r.dial_value  = dig_acc;
               cur_state     = PS_IDLE;
            end else begin
               r.action  = psc_pkg::ACT_BAD_COMMAND;
               cur_state = PS_IDLE;
            end
         end
         PS_TERM1: begin
            cur_state = PS_IDLE;
            if (b != psc_pkg::CR_BYTE) r.action = psc_pkg::ACT_BAD_COMMAND;
            else begin
               r.channel_out = held_chan;
               if (held_val == VAL_ON) r.action = psc_pkg::ACT_POWER_ON;
               else if (held_val == VAL_OFF) r.action = psc_pkg::ACT_POWER_OFF;
               else if (held_cmd == CMD_POSITIVE || held_cmd == CMD_NEGATIVE) begin
                  r.action      = psc_pkg::ACT_METER_READ;
                  r.meter_index = {held_chan, held_cmd == CMD_NEGATIVE, held_val == VAL_AMPS};
               end else r.action = psc_pkg::ACT_REPORT_ONLY;
            end
         end
         default: begin
            // idle, and any stray state, waits for a channel letter
            cur_state = PS_IDLE;
            if (u >= "A" && u <= "D") begin
               held_chan = u[1:0] - 2'd1;
               cur_state = PS_CMD;
            end
         end
      endcase
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // Predict on each accepted byte, then compare each accepted result with the oldest expectation
   always @(posedge clock) begin : scoreboard
      psc_pkg::rsp_type predicted;
      psc_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            predicted = decode_byte(req_rx_byte);
            expected_rsps.push_back(pin_expected ? pinned_rsp : predicted);
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               $error("result transaction with no expectation waiting");
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               check_field("action", want.action, rsp_action);
               check_field("channel_out", want.channel_out, rsp_channel_out);
               check_field("meter_index", want.meter_index, rsp_meter_index);
               check_field("dial_index", want.dial_index, rsp_dial_index);
               check_field("dial_value", want.dial_value, rsp_dial_value);
            end
         end
      end
   end

   // Receiver: a new stall pattern is picked each time the 6-bit stall counter wraps to zero
   always @(posedge clock) begin
      if (stall_count == 0) stall_mode <= ready_mode_type'($urandom_range(0, 3));
      stall_count <= stall_count - 6'd1;
      case (stall_mode)
         RDY_ALWAYS:  rsp_ready <= 1'b1;
         RDY_RANDOM:  rsp_ready <= ($urandom_range(0, 9) < 7);
         RDY_QUARTER: rsp_ready <= (stall_count[1:0] == 2'd0);
         default:     rsp_ready <= (stall_count[3:0] == 4'd0);
      endcase
   end

   // Offer one byte and hold it until accepted; gaps fall between bursts
   task automatic send_byte(input logic [7:0] b, input logic pinned,
                            input psc_pkg::rsp_type want);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                 : $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid    <= 1'b1;
      req_rx_byte  <= b;
      pin_expected <= pinned;
      pinned_rsp   <= want;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic add_row(input logic [7:0] b, input logic pinned = 1'b0,
                          input psc_pkg::action_type act = psc_pkg::ACT_NONE,
                          input logic [1:0] ch = '0,
                          input logic [3:0] mi = '0, input logic [2:0] di = '0,
                          input logic [13:0] dv = '0);
      stim_row_type row;
      row.rx_byte            = b;
      row.pinned             = pinned;
      row.want.action        = act;
      row.want.channel_out   = ch;
      row.want.meter_index   = mi;
      row.want.dial_index    = di;
      row.want.dial_value    = dv;
      directed_rows.push_back(row);
   endtask

   function automatic logic [7:0] any_case(input logic [7:0] upper);
      return upper | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
   endfunction

   // A well-formed command in random case; five_digits gives a dial with one digit too many
   task automatic build_command(input bit five_digits);
      int n_digits;
      bit all_nines;
      command_bytes.delete();
      command_bytes.push_back(any_case("A" + 8'($urandom_range(0, 3))));
      if (!five_digits && $urandom_range(0, 1)) begin
         case ($urandom_range(0, 2))
            0:       command_bytes.push_back(any_case("Z"));
            1:       command_bytes.push_back(any_case("P"));
            default: command_bytes.push_back(any_case("N"));
         endcase
         case ($urandom_range(0, 3))
            0:       command_bytes.push_back("1");
            1:       command_bytes.push_back("0");
            2:       command_bytes.push_back(any_case("V"));
            default: command_bytes.push_back(any_case("I"));
         endcase
      end else begin
         command_bytes.push_back(any_case($urandom_range(0, 1) ? "M" : "S"));
         n_digits  = five_digits ? 5 : $urandom_range(1, 4);
         all_nines = ($urandom_range(0, 15) == 0);
         repeat (n_digits)
            command_bytes.push_back(all_nines ? "9" : "0" + 8'($urandom_range(0, 9)));
      end
      command_bytes.push_back(psc_pkg::CR_BYTE);
   endtask

   // Stimulus
   initial begin : stimulus
      int payload_count;
      int kind;
      int pos;
      int wait_cycles;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed table
      add_row(8'hFF, 1'b1, psc_pkg::ACT_NONE);   // unknown byte in idle is ignored
      add_row("A");
      add_row("z");
      add_row("1");
      add_row(psc_pkg::CR_BYTE, 1'b1, psc_pkg::ACT_POWER_ON, 2'd0);
      add_row("d");
      add_row("P");
      add_row("0");                              // power value after P
      add_row(psc_pkg::CR_BYTE, 1'b1, psc_pkg::ACT_POWER_OFF, 2'd3);
      add_row("b");
      add_row("n");
      add_row("i");
      add_row(psc_pkg::CR_BYTE);                 // meter read
      add_row("C");
      add_row("s");
      repeat (4) add_row("9");
      add_row("9", 1'b1, psc_pkg::ACT_BAD_COMMAND);   // fifth digit
      add_row("D");
      add_row("M");
      add_row("0");
      add_row(psc_pkg::CR_BYTE, 1'b1, psc_pkg::ACT_DIAL_SET, 2'd3, 4'd0, 3'd6, 14'd0);
      add_row("a");
      add_row("Z");
      add_row("v");
      // meter value after Z
      add_row(psc_pkg::CR_BYTE, 1'b1, psc_pkg::ACT_REPORT_ONLY, 2'd0);
      add_row("B");
      add_row("#", 1'b1, psc_pkg::ACT_BAD_COMMAND);
      foreach (directed_rows[i])
         send_byte(directed_rows[i].rx_byte, directed_rows[i].pinned, directed_rows[i].want);

      // Random commands: mostly well formed, some broken, some line noise
      payload_count = 0;
      while (payload_count < RANDOM_BYTES) begin
         kind = $urandom_range(0, 99);
         if (kind < 10) begin
            command_bytes.delete();
            repeat ($urandom_range(1, 3)) command_bytes.push_back(8'($urandom_range(0, 255)));
         end else begin
            build_command(kind >= 80 && kind < 85);
            if (kind >= 85) begin
               // corrupt one byte and cut the command short after it
               pos = $urandom_range(1, command_bytes.size() - 1);
               case ($urandom_range(0, 2))
                  0:       command_bytes[pos] = psc_pkg::CR_BYTE;
                  1:       command_bytes[pos] = 8'($urandom_range(8'h20, 8'h7E));
                  default: command_bytes[pos] = 8'($urandom_range(0, 255));
               endcase
               while (command_bytes.size() > pos + 1) void'(command_bytes.pop_back());
            end
            payload_count += command_bytes.size();
         end
         foreach (command_bytes[i]) send_byte(command_bytes[i], 1'b0, '0);
      end
      req_valid <= 1'b0;

      // Drain
      wait_cycles = 0;
      while (expected_rsps.size() != 0 && wait_cycles < 5000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (20) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d expected results never arrived", expected_rsps.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("psu_serial_command_decoder_tb OK");
      end else begin
         $display("psu_serial_command_decoder_tb NOT OK");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("psu_serial_command_decoder_tb NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/psc_pkg.sv
sv/psc_in_reg.sv
sv/psc_parse.sv
sv/psu_serial_command_decoder.sv
verif/psu_serial_command_decoder_tb.sv
